FILE: rtl/point_rotate_and_project_macros.svh
// Assertion macros for the point rotate and project block.
// Used by rtl/point_rotate_and_project.sv; expects clock and reset in scope.
`ifndef POINT_ROTATE_AND_PROJECT_MACROS_SVH
`define POINT_ROTATE_AND_PROJECT_MACROS_SVH

// same-cycle implication
`define PRP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PRP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/prp_pkg.sv
// Shared constants and register index codes for the point rotate and project block.
// No dependencies.
package prp_pkg;

   localparam int COORD_WIDTH_DEF      = 32;
   localparam int TRIG_FRAC_BITS_DEF   = 14;
   localparam int TRIG_WIDTH           = 16;
   localparam int CFG_WIDTH            = 32;
   localparam int COLOUR_WIDTH         = 32;
   localparam int CSR_ADDR_WIDTH       = 3;
   localparam int CSR_DATA_WIDTH       = 32;
   localparam int DIV_BITS_PER_STAGE   = 2;

   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE_RESET  = 16'sd16384;
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ZERO_RESET = 16'sd0;
   localparam logic signed [CFG_WIDTH-1:0]  VIEW_DIST_RESET = 32'sd65536;
   localparam logic signed [CFG_WIDTH-1:0]  ZOOM_RESET      = 32'sd65536;
   localparam logic signed [CFG_WIDTH-1:0]  CENTRE_RESET    = 32'sd0;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_COS_X     = 3'd0,
      CSR_SIN_X     = 3'd1,
      CSR_COS_Z     = 3'd2,
      CSR_SIN_Z     = 3'd3,
      CSR_VIEW_DIST = 3'd4,
      CSR_ZOOM      = 3'd5,
      CSR_CENTRE_X  = 3'd6,
      CSR_CENTRE_Y  = 3'd7
   } csr_index_type;

endpackage

FILE: rtl/point_rotate_and_project.sv
// Channel  | Ports                                   | Transfer carries
// ---------+-----------------------------------------+-----------------------------------------
// request  | req_tvalid/tready/tdata/tlast           | point_x, point_y, point_z, colour; last
// response | rsp_tvalid/tready/tdata/tuser/tlast     | screen_x, screen_y, depth, colour_out;
//          |                                         | behind_camera in tuser; last_out in tlast
// config   | csr_we/csr_addr/csr_wdata               | one register write per cycle
//
// One transfer per clock in and out while the response is not stalled (rsp_tready low).
// The quotient pipeline has NDS stages and retires two quotient bits per stage.
// Every stage has its own valid bit and moves when the stage after it is empty or moving,
// so bubbles are squeezed out and a stalled response holds only the stages behind it.
// Reset is synchronous; it clears the valid bits and loads the register defaults. No clearing
// pass is needed. The user must write registers only while the pipe is empty; the block does not enforce it.
//
// Holds the whole datapath: rotation, depth add, zoom multiply, pipelined divide, offset.
// Depends on rtl/prp_pkg.sv and rtl/point_rotate_and_project_macros.svh.
`include "point_rotate_and_project_macros.svh"

module point_rotate_and_project #(
   parameter int COORD_WIDTH    = prp_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = prp_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // point_x, point_y, point_z, colour, zero pad
   input  logic [((3*COORD_WIDTH+prp_pkg::COLOUR_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // screen_x, screen_y, depth, colour_out, zero pad
   output logic [((3*COORD_WIDTH+prp_pkg::COLOUR_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tuser,  // behind_camera
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [prp_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [prp_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int CW   = COORD_WIDTH;
   localparam int TW   = prp_pkg::TRIG_WIDTH;
   localparam int TFB  = TRIG_FRAC_BITS;
   localparam int ZW   = prp_pkg::CFG_WIDTH;
   localparam int COLW = prp_pkg::COLOUR_WIDTH;
   localparam int P1W  = CW + TW;            // coord x trig product
   localparam int S1W  = P1W + 2;            // first rotation sum
   localparam int TTW  = S1W - TFB;          // unsaturated intermediate t
   localparam int P2W  = TTW + TW;           // t x trig product
   localparam int S2W  = P2W + 2;            // second rotation sum
   localparam int DW   = ((CW > ZW) ? CW : ZW) + 1;  // depth + distance, signed
   localparam int DUW  = DW - 1;             // divisor magnitude
   localparam int PZW  = CW + ZW;            // coord x zoom product
   localparam int NW   = PZW - 1;            // dividend magnitude
   localparam int KB   = prp_pkg::DIV_BITS_PER_STAGE;
   localparam int QB   = ((DW + KB - 1) / KB) * KB;  // quotient bits kept
   localparam int NDS  = QB / KB;            // divider stages
   localparam int QSW  = QB + 2;             // quotient + centre sum
   localparam int SATW = (S2W > S1W) ? ((S2W > QSW) ? S2W : QSW)
                                     : ((S1W > QSW) ? S1W : QSW);
   localparam int ST_G = NDS + 6;
   localparam int ST_H = NDS + 7;
   localparam int L    = NDS + 8;
   localparam int PAYW = 3*CW + COLW;
   localparam int DATW = ((PAYW + 7) / 8) * 8;

   localparam logic signed [S1W-1:0] HALF1 = S1W'(1) << (TFB - 1);
   localparam logic signed [S2W-1:0] HALF2 = S2W'(1) << (TFB - 1);
   localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   function automatic logic [CW-1:0] sat_c(input logic signed [SATW-1:0] v);
      logic ok;
      ok = (&v[SATW-1:CW-1]) | ~(|v[SATW-1:CW-1]);
      sat_c = ok ? v[CW-1:0] : (v[SATW-1] ? CMIN : CMAX);
   endfunction

   // restoring division, KB quotient bits; result is {remainder, shifted dividend/quotient}
   function automatic logic [DUW+QB-1:0] div_step(input logic [DUW-1:0] r_i,
                                                  input logic [QB-1:0] nq_i,
                                                  input logic [DUW-1:0] dv);
      logic [DUW:0]   r2;
      logic [DUW-1:0] r;
      logic [QB-1:0]  nq;
      r  = r_i;
      nq = nq_i;
      for (int j = 0; j < KB; j++) begin
         r2 = {r, nq[QB-1]};
         nq = {nq[QB-2:0], 1'b0};
         if (r2 >= {1'b0, dv}) begin
            r2    = r2 - {1'b0, dv};
            nq[0] = 1'b1;
         end
         r = r2[DUW-1:0];
      end
      div_step = {r, nq};
   endfunction

   typedef struct packed {
      logic [QB-1:0]   nq_x;
      logic [QB-1:0]   nq_y;
      logic [DUW-1:0]  r_x;
      logic [DUW-1:0]  r_y;
      logic [DUW-1:0]  dvsr;
      logic            ovf_x;
      logic            ovf_y;
      logic            neg_x;
      logic            neg_y;
      logic [CW-1:0]   depth;
      logic            behind;
      logic [COLW-1:0] colour;
      logic            last;
   } div_type;

   // ---------------- configuration registers ----------------
   logic signed [TW-1:0] cos_x_ff, sin_x_ff, cos_z_ff, sin_z_ff;
   logic signed [ZW-1:0] view_dist_ff, zoom_ff, centre_x_ff, centre_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_x_ff     <= prp_pkg::TRIG_ONE_RESET;
         sin_x_ff     <= prp_pkg::TRIG_ZERO_RESET;
         cos_z_ff     <= prp_pkg::TRIG_ONE_RESET;
         sin_z_ff     <= prp_pkg::TRIG_ZERO_RESET;
         view_dist_ff <= prp_pkg::VIEW_DIST_RESET;
         zoom_ff      <= prp_pkg::ZOOM_RESET;
         centre_x_ff  <= prp_pkg::CENTRE_RESET;
         centre_y_ff  <= prp_pkg::CENTRE_RESET;
      end else if (csr_we) begin
         unique case (prp_pkg::csr_index_type'(csr_addr))
            prp_pkg::CSR_COS_X:     cos_x_ff     <= csr_wdata[TW-1:0];
            prp_pkg::CSR_SIN_X:     sin_x_ff     <= csr_wdata[TW-1:0];
            prp_pkg::CSR_COS_Z:     cos_z_ff     <= csr_wdata[TW-1:0];
            prp_pkg::CSR_SIN_Z:     sin_z_ff     <= csr_wdata[TW-1:0];
            prp_pkg::CSR_VIEW_DIST: view_dist_ff <= csr_wdata[ZW-1:0];
            prp_pkg::CSR_ZOOM:      zoom_ff      <= csr_wdata[ZW-1:0];
            prp_pkg::CSR_CENTRE_X:  centre_x_ff  <= csr_wdata[ZW-1:0];
            prp_pkg::CSR_CENTRE_Y:  centre_y_ff  <= csr_wdata[ZW-1:0];
         endcase
      end
   end

   // ---------------- valid bits and stage enables ----------------
   logic [L-1:0] v_ff, v_in;
   logic [L:0]   en;

   // a stage may load when it is empty or its content moves on
   always_comb begin
      en[L] = rsp_tready;
      for (int i = L - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign v_in = {v_ff[L-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en[L-1:0] & v_in) | (~en[L-1:0] & v_ff);
      end
   end

   assign req_tready = en[0];

   // ---------------- stage A: z-rotation and y products ----------------
   logic signed [CW-1:0] px, py, pz;
   logic signed [P1W-1:0] a_pxcz_in, a_pzsz_in, a_pxsz_in, a_pzcz_in, a_pycx_in, a_pysx_in;
   logic signed [P1W-1:0] a_pxcz_ff, a_pzsz_ff, a_pxsz_ff, a_pzcz_ff, a_pycx_ff, a_pysx_ff;
   logic [COLW-1:0] a_colour_ff;
   logic            a_last_ff;

   assign px = $signed(req_tdata[CW-1:0]);
   assign py = $signed(req_tdata[2*CW-1:CW]);
   assign pz = $signed(req_tdata[3*CW-1:2*CW]);

   assign a_pxcz_in = P1W'(px) * P1W'(cos_z_ff);
   assign a_pzsz_in = P1W'(pz) * P1W'(sin_z_ff);
   assign a_pxsz_in = P1W'(px) * P1W'(sin_z_ff);
   assign a_pzcz_in = P1W'(pz) * P1W'(cos_z_ff);
   assign a_pycx_in = P1W'(py) * P1W'(cos_x_ff);
   assign a_pysx_in = P1W'(py) * P1W'(sin_x_ff);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_pxcz_ff   <= a_pxcz_in;
         a_pzsz_ff   <= a_pzsz_in;
         a_pxsz_ff   <= a_pxsz_in;
         a_pzcz_ff   <= a_pzcz_in;
         a_pycx_ff   <= a_pycx_in;
         a_pysx_ff   <= a_pysx_in;
         a_colour_ff <= req_tdata[PAYW-1:3*CW];
         a_last_ff   <= req_tlast;
      end
   end

   // ---------------- stage B: round qx and t ----------------
   logic signed [S1W-1:0] b_qx_sum, b_t_sum;
   logic [CW-1:0]         b_qx_in, b_qx_ff;
   logic signed [TTW-1:0] b_t_in, b_t_ff;
   logic signed [P1W-1:0] b_pycx_ff, b_pysx_ff;
   logic [COLW-1:0]       b_colour_ff;
   logic                  b_last_ff;

   assign b_qx_sum = (S1W'(a_pxcz_ff) + S1W'(a_pzsz_ff) + HALF1) >>> TFB;
   assign b_t_sum  = (S1W'(a_pxsz_ff) - S1W'(a_pzcz_ff) + HALF1) >>> TFB;
   assign b_qx_in  = sat_c(SATW'(b_qx_sum));
   assign b_t_in   = b_t_sum[TTW-1:0];  // t stays unsaturated

   always_ff @(posedge clock) begin
      if (en[1]) begin
         b_qx_ff     <= b_qx_in;
         b_t_ff      <= b_t_in;
         b_pycx_ff   <= a_pycx_ff;
         b_pysx_ff   <= a_pysx_ff;
         b_colour_ff <= a_colour_ff;
         b_last_ff   <= a_last_ff;
      end
   end

   // ---------------- stage C: x-rotation products on t ----------------
   logic signed [P2W-1:0] c_tsx_in, c_tcx_in, c_tsx_ff, c_tcx_ff;
   logic signed [P1W-1:0] c_pycx_ff, c_pysx_ff;
   logic [CW-1:0]         c_qx_ff;
   logic [COLW-1:0]       c_colour_ff;
   logic                  c_last_ff;

   assign c_tsx_in = P2W'(b_t_ff) * P2W'(sin_x_ff);
   assign c_tcx_in = P2W'(b_t_ff) * P2W'(cos_x_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         c_tsx_ff    <= c_tsx_in;
         c_tcx_ff    <= c_tcx_in;
         c_pycx_ff   <= b_pycx_ff;
         c_pysx_ff   <= b_pysx_ff;
         c_qx_ff     <= b_qx_ff;
         c_colour_ff <= b_colour_ff;
         c_last_ff   <= b_last_ff;
      end
   end

   // ---------------- stage D: round and saturate qy, qz ----------------
   logic signed [S2W-1:0] d_qy_sum, d_qz_sum;
   logic [CW-1:0]         d_qy_in, d_qz_in, d_qx_ff, d_qy_ff, d_qz_ff;
   logic [COLW-1:0]       d_colour_ff;
   logic                  d_last_ff;

   assign d_qy_sum = (S2W'(c_pycx_ff) + S2W'(c_tsx_ff) + HALF2) >>> TFB;
   assign d_qz_sum = (S2W'(c_tcx_ff) - S2W'(c_pysx_ff) + HALF2) >>> TFB;
   assign d_qy_in  = sat_c(SATW'(d_qy_sum));
   assign d_qz_in  = sat_c(SATW'(d_qz_sum));

   always_ff @(posedge clock) begin
      if (en[3]) begin
         d_qx_ff     <= c_qx_ff;
         d_qy_ff     <= d_qy_in;
         d_qz_ff     <= d_qz_in;
         d_colour_ff <= c_colour_ff;
         d_last_ff   <= c_last_ff;
      end
   end

   // ---------------- stage E: divisor, behind test, zoom products ----------------
   logic signed [DW-1:0]  e_d_in, e_d_ff;
   logic                  e_behind_in, e_behind_ff;
   logic signed [PZW-1:0] e_px_in, e_py_in, e_px_ff, e_py_ff;
   logic [CW-1:0]         e_qz_ff;
   logic                  e_qxneg_ff, e_qyneg_ff;
   logic [COLW-1:0]       e_colour_ff;
   logic                  e_last_ff;

   assign e_d_in      = DW'($signed(d_qz_ff)) + DW'(view_dist_ff);
   assign e_behind_in = e_d_in[DW-1] | (e_d_in == '0);
   assign e_px_in     = PZW'($signed(d_qx_ff)) * PZW'(zoom_ff);
   assign e_py_in     = PZW'($signed(d_qy_ff)) * PZW'(zoom_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         e_d_ff      <= e_d_in;
         e_behind_ff <= e_behind_in;
         e_px_ff     <= e_px_in;
         e_py_ff     <= e_py_in;
         e_qz_ff     <= d_qz_ff;
         e_qxneg_ff  <= d_qx_ff[CW-1];
         e_qyneg_ff  <= d_qy_ff[CW-1];
         e_colour_ff <= d_colour_ff;
         e_last_ff   <= d_last_ff;
      end
   end

   // ---------------- stage F: magnitudes, overflow, divider load ----------------
   // A quotient of 2^QB or more saturates for any centre, so the top dividend bits
   // only need a compare and then seed the remainder.
   div_type div_ff [NDS+1];
   div_type div_in [NDS+1];
   logic signed [PZW-1:0] f_absx, f_absy;
   logic [NW-1:0]         f_magx, f_magy;

   assign f_absx = e_px_ff[PZW-1] ? -e_px_ff : e_px_ff;
   assign f_absy = e_py_ff[PZW-1] ? -e_py_ff : e_py_ff;
   assign f_magx = f_absx[NW-1:0];
   assign f_magy = f_absy[NW-1:0];

   always_comb begin
      div_in[0].dvsr   = e_d_ff[DUW-1:0];
      div_in[0].r_x    = DUW'(f_magx[NW-1:QB]);
      div_in[0].r_y    = DUW'(f_magy[NW-1:QB]);
      div_in[0].nq_x   = f_magx[QB-1:0];
      div_in[0].nq_y   = f_magy[QB-1:0];
      div_in[0].ovf_x  = e_behind_ff | (DUW'(f_magx[NW-1:QB]) >= e_d_ff[DUW-1:0]);
      div_in[0].ovf_y  = e_behind_ff | (DUW'(f_magy[NW-1:QB]) >= e_d_ff[DUW-1:0]);
      // behind camera: saturate by the sign of the rotated coordinate
      div_in[0].neg_x  = e_behind_ff ? e_qxneg_ff : e_px_ff[PZW-1];
      div_in[0].neg_y  = e_behind_ff ? e_qyneg_ff : e_py_ff[PZW-1];
      div_in[0].depth  = e_qz_ff;
      div_in[0].behind = e_behind_ff;
      div_in[0].colour = e_colour_ff;
      div_in[0].last   = e_last_ff;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         div_ff[0] <= div_in[0];
      end
   end

   // ---------------- quotient pipeline ----------------
   for (genvar k = 1; k <= NDS; k++) begin : g_div
      always_comb begin
         div_in[k] = div_ff[k-1];
         {div_in[k].r_x, div_in[k].nq_x} =
            div_step(div_ff[k-1].r_x, div_ff[k-1].nq_x, div_ff[k-1].dvsr);
         {div_in[k].r_y, div_in[k].nq_y} =
            div_step(div_ff[k-1].r_y, div_ff[k-1].nq_y, div_ff[k-1].dvsr);
      end

      always_ff @(posedge clock) begin
         if (en[5+k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // ---------------- stage G: signed quotients ----------------
   logic signed [QB:0] g_magx, g_magy, g_qx_in, g_qy_in, g_qx_ff, g_qy_ff;
   logic               g_ovf_x_ff, g_ovf_y_ff, g_neg_x_ff, g_neg_y_ff;
   logic [CW-1:0]      g_depth_ff;
   logic               g_behind_ff;
   logic [COLW-1:0]    g_colour_ff;
   logic               g_last_ff;

   assign g_magx  = $signed({1'b0, div_ff[NDS].nq_x});
   assign g_magy  = $signed({1'b0, div_ff[NDS].nq_y});
   assign g_qx_in = div_ff[NDS].neg_x ? -g_magx : g_magx;
   assign g_qy_in = div_ff[NDS].neg_y ? -g_magy : g_magy;

   always_ff @(posedge clock) begin
      if (en[ST_G]) begin
         g_qx_ff     <= g_qx_in;
         g_qy_ff     <= g_qy_in;
         g_ovf_x_ff  <= div_ff[NDS].ovf_x;
         g_ovf_y_ff  <= div_ff[NDS].ovf_y;
         g_neg_x_ff  <= div_ff[NDS].neg_x;
         g_neg_y_ff  <= div_ff[NDS].neg_y;
         g_depth_ff  <= div_ff[NDS].depth;
         g_behind_ff <= div_ff[NDS].behind;
         g_colour_ff <= div_ff[NDS].colour;
         g_last_ff   <= div_ff[NDS].last;
      end
   end

   // ---------------- stage H: centre offset, saturation, output register ----------------
   logic signed [QSW-1:0] h_sumx, h_sumy;
   logic [CW-1:0]         h_sx_in, h_sy_in, h_sx_ff, h_sy_ff, h_depth_ff;
   logic                  h_behind_ff, h_last_ff;
   logic [COLW-1:0]       h_colour_ff;

   assign h_sumx  = QSW'(g_qx_ff) + QSW'(centre_x_ff);
   assign h_sumy  = QSW'(g_qy_ff) + QSW'(centre_y_ff);
   assign h_sx_in = g_ovf_x_ff ? (g_neg_x_ff ? CMIN : CMAX) : sat_c(SATW'(h_sumx));
   assign h_sy_in = g_ovf_y_ff ? (g_neg_y_ff ? CMIN : CMAX) : sat_c(SATW'(h_sumy));

   always_ff @(posedge clock) begin
      if (en[ST_H]) begin
         h_sx_ff     <= h_sx_in;
         h_sy_ff     <= h_sy_in;
         h_depth_ff  <= g_depth_ff;
         h_behind_ff <= g_behind_ff;
         h_colour_ff <= g_colour_ff;
         h_last_ff   <= g_last_ff;
      end
   end

   assign rsp_tvalid = v_ff[ST_H];
   assign rsp_tdata  = DATW'({h_colour_ff, h_depth_ff, h_sy_ff, h_sx_ff});
   assign rsp_tuser  = h_behind_ff;
   assign rsp_tlast  = h_last_ff;

   // ---------------- assertions ----------------
   `PRP_ASSERT_NOW(a_behind_sat, rsp_tvalid && rsp_tuser, (h_sx_ff == CMAX || h_sx_ff == CMIN) && (h_sy_ff == CMAX || h_sy_ff == CMIN), "behind-camera result not saturated")
   `PRP_ASSERT_NOW(a_full_stall, (&v_ff) && !rsp_tready, !req_tready, "request taken into a full stalled pipe")
   `PRP_ASSERT_NEXT(a_advance, v_ff[0] && en[1], v_ff[1], "item lost between first stages")
   `PRP_ASSERT_NOW(a_rem_bound, v_ff[ST_G-1] && !div_ff[NDS].ovf_x, div_ff[NDS].r_x < div_ff[NDS].dvsr, "divider remainder out of range")
   `PRP_ASSERT_NEXT(a_zoom_write, csr_we && csr_addr == prp_pkg::CSR_ZOOM, zoom_ff == $past(csr_wdata[ZW-1:0]), "zoom write not taken")

endmodule
